>>> hw/rtl/btint_pkg.sv
// Shared types, constants and helpers for the ball trajectory integrator.
`timescale 1ns / 1ps
package btint_pkg;

    // largest step count per advance and the width that holds it
    localparam int MAX_STEPS = 256;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    // iterative divider sizes: 64-bit dividend, divisor up to step_length << 16
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 47;

    // accumulator width: holds a full signed 33 x 33 product
    localparam int ACC_W = 66;

    // register reset values
    localparam logic signed [31:0] START_X_RST  = -32'sd1441792;
    localparam logic        [30:0] STEP_LEN_RST = 31'd15838;
    localparam logic signed [31:0] GRAVITY_RST  = -32'sd2108293;

    localparam logic signed [ACC_W-1:0] I32_MAX_W = 66'sd2147483647;
    localparam logic signed [ACC_W-1:0] I32_MIN_W = -66'sd2147483648;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_DRAG_LAM  = 3'd0,
        CFG_DRAG_TUR  = 3'd1,
        CFG_CRIT_SPD  = 3'd2,
        CFG_LIFT_DEC  = 3'd3,
        CFG_START_X   = 3'd4,
        CFG_STEP_LEN  = 3'd5,
        CFG_GRAVITY   = 3'd6
    } t_cfg_idx;

    // product selected for the shared multiplier
    typedef enum logic [3:0] {
        MOP_NONE, MOP_VXVX, MOP_VYVY, MOP_DRAGV, MOP_DVVX, MOP_LIFTVY, MOP_DVVY,
        MOP_LIFTVX, MOP_AXDT, MOP_AYDT, MOP_VXDT, MOP_DVXDT, MOP_VYDT, MOP_DVYDT,
        MOP_LDECDT, MOP_DXQ
    } t_mop;

    // accumulator operation applied to the shifted product
    typedef enum logic [2:0] {
        AOP_NONE, AOP_LOAD, AOP_NEG, AOP_ADD, AOP_SUBG, AOP_LDX, AOP_LDY, AOP_LDL
    } t_aop;

    // where the new accumulator value is written
    typedef enum logic [3:0] {
        DST_NONE, DST_SQ, DST_DIVQ, DST_DV, DST_AX, DST_AY, DST_DVX, DST_DVY,
        DST_NX, DST_NY, DST_NL
    } t_dest;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE, S_DXQ, S_D1L, S_D1W, S_CNT, S_D2L, S_D2W, S_DT,
        S_M1, S_M2, S_SQL, S_SQW, S_M3, S_N3, S_M4, S_M5, S_M6, S_M7, S_M8,
        S_M9, S_M10, S_M11, S_M12, S_M13, S_M14, S_DRN, S_COM, S_FIN
    } t_state;

    typedef struct packed {
        logic  ld_start;
        logic  ld_adv;
        t_mop  mop;
        t_aop  aop;
        t_dest dest;
        logic  go_cnt;
        logic  go_dt;
        logic  commit;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic sq_busy;
        logic div_busy;
        logic last_step;
        logic out_free;
    } t_stat;

    function automatic logic signed [ACC_W-1:0] ext66(input logic signed [31:0] v);
        return {{(ACC_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > I32_MAX_W) return 32'sh7FFFFFFF;
        if (v < I32_MIN_W) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

>>> hw/rtl/ball_trajectory_integrator.sv
// Top level of the ball trajectory integrator: controller plus datapath.
`timescale 1ns / 1ps
// Input channel (i_in_valid / o_in_stall) carries a start word (operation 0)
// or an advance word (operation 1). A start word loads time, height,
// velocities and lift; x comes from the start_x register and
// no result follows. An advance word gives a target time; the block picks
// the step count, integrates and returns one result word on the output
// channel (o_out_valid / i_out_stall) with x, y, time, steps and clip flag.
// An advance makes two passes of the bit-serial divider (step count, then
// dt), and per step a bit-serial square root plus 14 issues of the shared
// 33x33 multiplier. One word is in work at a time; the input is stalled until
// the result sits in the output register. A stalled result holds there while
// the next word is accepted. Configuration writes take effect at once. The
// user must make them only while idle; the block does not enforce this.
// Reset (synchronous, active low) zeroes the ball state, loads register
// defaults and empties the output register; no clearing pass is needed.
module ball_trajectory_integrator import btint_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic signed [31:0] i_time_value,
    input  logic signed [31:0] i_start_height,
    input  logic signed [31:0] i_start_vx,
    input  logic signed [31:0] i_start_vy,
    input  logic signed [31:0] i_start_lift,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_time_reached,
    output logic [STEP_W-1:0]  o_steps_taken,
    output logic               o_steps_clipped
);

    t_cmd  cmd;
    t_stat stat;

    btint_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    btint_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_time_value    (i_time_value),
        .i_start_height  (i_start_height),
        .i_start_vx      (i_start_vx),
        .i_start_vy      (i_start_vy),
        .i_start_lift    (i_start_lift),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_time_reached  (o_time_reached),
        .o_steps_taken   (o_steps_taken),
        .o_steps_clipped (o_steps_clipped)
    );

endmodule

>>> hw/rtl/btint_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module btint_sqrt import btint_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_busy,
    output logic [31:0] o_root
);

    logic [63:0] r_rem, r_res, r_bit;
    logic        r_busy;
    logic [64:0] trial;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};

    // classic digit recurrence, bit walks down two places a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit == 64'd1) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_val;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if ({1'b0, r_rem} >= trial) begin
                r_rem <= r_rem - trial[63:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[31:0];

endmodule

>>> hw/rtl/btint_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module btint_div import btint_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_busy,
    output logic [DIV_NW-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic [DIV_DW-1:0] r_rem, r_den;
    logic [DIV_NW-1:0] r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [DIV_DW:0]   rem_sh, rem_sub;
    logic              q_bit;

    assign rem_sh  = {r_rem, r_q[DIV_NW-1]};
    assign q_bit   = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // busy flag and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_NW - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) r_busy <= 1'b0;
        end
    end

    // dividend shifts out the top while quotient bits enter the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            r_q   <= {r_q[DIV_NW-2:0], q_bit};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;

endmodule

>>> hw/rtl/btint_ctrl.sv
// Sequencer for the integrator: issues datapath commands per state.
`timescale 1ns / 1ps
module btint_ctrl import btint_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_operation,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   take;

    assign take = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (take && i_operation) n_state = S_DXQ;
            S_DXQ:  n_state = S_D1L;
            S_D1L:  n_state = S_D1W;
            S_D1W:  if (!i_stat.div_busy) n_state = S_CNT;
            S_CNT:  n_state = S_D2L;
            S_D2L:  n_state = S_D2W;
            S_D2W:  if (!i_stat.div_busy) n_state = S_DT;
            S_DT:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_SQL;
            S_SQL:  n_state = S_SQW;
            S_SQW:  if (!i_stat.sq_busy) n_state = S_M3;
            S_M3:   n_state = S_N3;
            S_N3:   n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = S_M6;
            S_M6:   n_state = S_M7;
            S_M7:   n_state = S_M8;
            S_M8:   n_state = S_M9;
            S_M9:   n_state = S_M10;
            S_M10:  n_state = S_M11;
            S_M11:  n_state = S_M12;
            S_M12:  n_state = S_M13;
            S_M13:  n_state = S_M14;
            S_M14:  n_state = S_DRN;
            S_DRN:  n_state = S_COM;
            S_COM:  n_state = i_stat.last_step ? S_FIN : S_M1;
            S_FIN:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.mop      = MOP_NONE;
        o_cmd.aop      = AOP_NONE;
        o_cmd.dest     = DST_NONE;
        o_cmd.ld_start = take && !i_operation;
        o_cmd.ld_adv   = take && i_operation;
        unique case (r_state)
            S_DXQ: begin o_cmd.mop = MOP_DXQ;    o_cmd.aop = AOP_LOAD; o_cmd.dest = DST_DIVQ; end
            S_CNT: o_cmd.go_cnt = 1'b1;
            S_DT:  o_cmd.go_dt = 1'b1;
            S_M1:  begin o_cmd.mop = MOP_VXVX;   o_cmd.aop = AOP_LOAD; end
            S_M2:  begin o_cmd.mop = MOP_VYVY;   o_cmd.aop = AOP_ADD;  o_cmd.dest = DST_SQ;  end
            S_M3:  begin o_cmd.mop = MOP_DRAGV;  o_cmd.aop = AOP_LOAD; o_cmd.dest = DST_DV;  end
            S_M4:  begin o_cmd.mop = MOP_DVVX;   o_cmd.aop = AOP_NEG;  end
            S_M5:  begin o_cmd.mop = MOP_LIFTVY; o_cmd.aop = AOP_ADD;  o_cmd.dest = DST_AX;  end
            S_M6:  begin o_cmd.mop = MOP_DVVY;   o_cmd.aop = AOP_NEG;  end
            S_M7:  begin o_cmd.mop = MOP_LIFTVX; o_cmd.aop = AOP_SUBG; o_cmd.dest = DST_AY;  end
            S_M8:  begin o_cmd.mop = MOP_AXDT;   o_cmd.aop = AOP_LOAD; o_cmd.dest = DST_DVX; end
            S_M9:  begin o_cmd.mop = MOP_AYDT;   o_cmd.aop = AOP_LOAD; o_cmd.dest = DST_DVY; end
            S_M10: begin o_cmd.mop = MOP_VXDT;   o_cmd.aop = AOP_LDX;  end
            S_M11: begin o_cmd.mop = MOP_DVXDT;  o_cmd.aop = AOP_ADD;  o_cmd.dest = DST_NX;  end
            S_M12: begin o_cmd.mop = MOP_VYDT;   o_cmd.aop = AOP_LDY;  end
            S_M13: begin o_cmd.mop = MOP_DVYDT;  o_cmd.aop = AOP_ADD;  o_cmd.dest = DST_NY;  end
            S_M14: begin o_cmd.mop = MOP_LDECDT; o_cmd.aop = AOP_LDL;  o_cmd.dest = DST_NL;  end
            S_COM: o_cmd.commit = 1'b1;
            S_FIN: o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> hw/rtl/btint_datapath.sv
// Integrator datapath: registers, shared multiplier, accumulator, output word.
`timescale 1ns / 1ps
module btint_datapath import btint_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_time_value,
    input  logic signed [31:0] i_start_height,
    input  logic signed [31:0] i_start_vx,
    input  logic signed [31:0] i_start_vy,
    input  logic signed [31:0] i_start_lift,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_time_reached,
    output logic [STEP_W-1:0]  o_steps_taken,
    output logic               o_steps_clipped
);

    // configuration
    logic [30:0]        r_drag_lam, r_drag_tur, r_crit, r_step_len;
    logic signed [31:0] r_lift_dec, r_start_x, r_grav;
    // ball state
    logic signed [31:0] r_time, r_x, r_y, r_vx, r_vy, r_lift;
    // per-advance and per-step working values
    logic signed [32:0] r_delta;
    logic signed [31:0] r_dt, r_dv, r_ax, r_ay, r_dvx, r_dvy, r_nx, r_ny, r_nl;
    logic [STEP_W-1:0]  r_steps, r_cnt;
    logic               r_clip;
    // multiplier pipeline
    logic signed [ACC_W-1:0] r_prod, r_acc, n_acc, prod_w, sh;
    t_mop               r_mop_d;
    t_aop               r_aop_d;
    t_dest              r_dst_d;
    logic signed [32:0] mul_a, mul_b;
    // output word
    logic               r_ovalid;
    logic signed [31:0] r_ox, r_oy, r_ot;
    logic [STEP_W-1:0]  r_osteps;
    logic               r_oclip;

    logic [30:0]        drag_sel, len_eff;
    logic [31:0]        root;
    logic               sq_start, sq_busy, div_start, div_busy;
    logic [DIV_NW-1:0]  div_num, div_quo;
    logic [DIV_DW-1:0]  div_den, den_step;
    logic               clip_w, out_free;
    logic [STEP_W-1:0]  steps_w;
    logic signed [33:0] delta_w, abs_d, dt_w;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drag_lam <= '0;
            r_drag_tur <= '0;
            r_crit     <= '0;
            r_lift_dec <= '0;
            r_start_x  <= START_X_RST;
            r_step_len <= STEP_LEN_RST;
            r_grav     <= GRAVITY_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DRAG_LAM: r_drag_lam <= i_cfg_data[30:0];
                CFG_DRAG_TUR: r_drag_tur <= i_cfg_data[30:0];
                CFG_CRIT_SPD: r_crit     <= i_cfg_data[30:0];
                CFG_LIFT_DEC: r_lift_dec <= i_cfg_data;
                CFG_START_X:  r_start_x  <= i_cfg_data;
                CFG_STEP_LEN: r_step_len <= i_cfg_data[30:0];
                CFG_GRAVITY:  r_grav     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand selection for the shared multiplier
    assign drag_sel = ({1'b0, root} < {2'b0, r_crit}) ? r_drag_lam : r_drag_tur;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mop)
            MOP_VXVX:   begin mul_a = 33'(r_vx);           mul_b = 33'(r_vx); end
            MOP_VYVY:   begin mul_a = 33'(r_vy);           mul_b = 33'(r_vy); end
            MOP_DRAGV:  begin mul_a = {2'b0, drag_sel};    mul_b = {1'b0, root}; end
            MOP_DVVX:   begin mul_a = 33'(r_dv);           mul_b = 33'(r_vx); end
            MOP_LIFTVY: begin mul_a = 33'(r_lift);         mul_b = 33'(r_vy); end
            MOP_DVVY:   begin mul_a = 33'(r_dv);           mul_b = 33'(r_vy); end
            MOP_LIFTVX: begin mul_a = 33'(r_lift);         mul_b = 33'(r_vx); end
            MOP_AXDT:   begin mul_a = 33'(r_ax);           mul_b = 33'(r_dt); end
            MOP_AYDT:   begin mul_a = 33'(r_ay);           mul_b = 33'(r_dt); end
            MOP_VXDT:   begin mul_a = 33'(r_vx);           mul_b = 33'(r_dt); end
            MOP_DVXDT:  begin mul_a = 33'(r_dvx);          mul_b = 33'(r_dt); end
            MOP_VYDT:   begin mul_a = 33'(r_vy);           mul_b = 33'(r_dt); end
            MOP_DVYDT:  begin mul_a = 33'(r_dvy);          mul_b = 33'(r_dt); end
            MOP_LDECDT: begin mul_a = 33'(r_lift_dec);     mul_b = 33'(r_dt); end
            MOP_DXQ:    begin mul_a = r_delta;             mul_b = 33'(r_vx); end
            default: ;
        endcase
    end

    assign prod_w = mul_a * mul_b;

    // product register and delayed accumulator command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mop_d <= MOP_NONE;
            r_aop_d <= AOP_NONE;
            r_dst_d <= DST_NONE;
        end else begin
            r_mop_d <= i_cmd.mop;
            r_aop_d <= i_cmd.aop;
            r_dst_d <= i_cmd.dest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_w;
        r_acc  <= n_acc;
    end

    // floor shift that matches each product's fixed-point format
    always_comb begin
        unique case (r_mop_d)
            MOP_DRAGV, MOP_LIFTVY, MOP_LIFTVX:  sh = r_prod >>> 28;
            MOP_DVXDT, MOP_DVYDT:               sh = r_prod >>> 17;
            MOP_DVVX, MOP_DVVY, MOP_AXDT, MOP_AYDT, MOP_VXDT, MOP_VYDT,
            MOP_LDECDT:                         sh = r_prod >>> 16;
            default:                            sh = r_prod;
        endcase
    end

    always_comb begin
        unique case (r_aop_d)
            AOP_LOAD: n_acc = sh;
            AOP_NEG:  n_acc = -sh;
            AOP_ADD:  n_acc = r_acc + sh;
            AOP_SUBG: n_acc = r_acc - sh + ext66(r_grav);
            AOP_LDX:  n_acc = ext66(r_x) + sh;
            AOP_LDY:  n_acc = ext66(r_y) + sh;
            AOP_LDL:  n_acc = ext66(r_lift) - sh;
            default:  n_acc = r_acc;
        endcase
    end

    // step count from the first quotient, clamped to 1..MAX_STEPS
    assign clip_w  = div_quo > DIV_NW'(MAX_STEPS);
    assign steps_w = clip_w ? STEP_W'(MAX_STEPS)
                   : (div_quo == '0) ? STEP_W'(1) : div_quo[STEP_W-1:0];

    // divider feed: rounded distance over step length, then |delta| over steps
    assign len_eff  = (r_step_len == '0) ? 31'd1 : r_step_len;
    assign den_step = {len_eff, 16'b0};
    assign delta_w  = {r_delta[32], r_delta};
    assign abs_d    = delta_w[33] ? -delta_w : delta_w;

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = den_step;
        if (r_dst_d == DST_DIVQ) begin
            div_start = 1'b1;
            if (n_acc > 0) div_num = n_acc[DIV_NW-1:0] + DIV_NW'(den_step >> 1);
        end else if (i_cmd.go_cnt) begin
            div_start = 1'b1;
            div_num   = DIV_NW'(abs_d[32:0]);
            div_den   = DIV_DW'(steps_w);
        end
    end

    // dt truncates toward zero: magnitude quotient takes the sign of delta
    assign dt_w = r_delta[32] ? -$signed({1'b0, div_quo[32:0]})
                              : $signed({1'b0, div_quo[32:0]});

    assign sq_start = (r_dst_d == DST_SQ);

    btint_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (n_acc[63:0]),
        .o_busy  (sq_busy),
        .o_root  (root)
    );

    btint_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // intermediate stores from the accumulator
    always_ff @(posedge i_clk) begin
        unique case (r_dst_d)
            DST_DV:  r_dv  <= sat32(n_acc);
            DST_AX:  r_ax  <= sat32(n_acc);
            DST_AY:  r_ay  <= sat32(n_acc);
            DST_DVX: r_dvx <= sat32(n_acc);
            DST_DVY: r_dvy <= sat32(n_acc);
            DST_NX:  r_nx  <= sat32(n_acc);
            DST_NY:  r_ny  <= sat32(n_acc);
            DST_NL:  r_nl  <= sat32(n_acc);
            default: ;
        endcase
        if (i_cmd.ld_adv) r_delta <= 33'(i_time_value) - 33'(r_time);
        if (i_cmd.go_dt)  r_dt    <= sat32({{(ACC_W-34){dt_w[33]}}, dt_w});
    end

    // ball state: load on start word, update at the end of each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_vx   <= '0;
            r_vy   <= '0;
            r_lift <= '0;
        end else if (i_cmd.ld_start) begin
            r_time <= i_time_value;
            r_x    <= r_start_x;
            r_y    <= i_start_height;
            r_vx   <= i_start_vx;
            r_vy   <= i_start_vy;
            r_lift <= i_start_lift;
        end else if (i_cmd.commit) begin
            r_time <= sat32(ext66(r_time) + ext66(r_dt));
            r_x    <= r_nx;
            r_y    <= r_ny;
            r_vx   <= sat32(ext66(r_vx) + ext66(r_dvx));
            r_vy   <= sat32(ext66(r_vy) + ext66(r_dvy));
            r_lift <= r_nl;
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_steps <= '0;
            r_clip  <= 1'b0;
        end else if (i_cmd.go_cnt) begin
            r_cnt   <= steps_w;
            r_steps <= steps_w;
            r_clip  <= clip_w;
        end else if (i_cmd.commit) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // output word register
    assign out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ox     <= r_x;
            r_oy     <= r_y;
            r_ot     <= r_time;
            r_osteps <= r_steps;
            r_oclip  <= r_clip;
        end
    end

    assign o_stat.sq_busy   = sq_busy;
    assign o_stat.div_busy  = div_busy;
    assign o_stat.last_step = (r_cnt == STEP_W'(1));
    assign o_stat.out_free  = out_free;

    assign o_out_valid     = r_ovalid;
    assign o_pos_x         = r_ox;
    assign o_pos_y         = r_oy;
    assign o_time_reached  = r_ot;
    assign o_steps_taken   = r_osteps;
    assign o_steps_clipped = r_oclip;

    // checks on sequencing between controller and datapath
    a_sq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy) else $error("square root restarted while busy");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_ovalid && i_out_stall))
        else $error("output word overwritten while stalled");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> r_cnt != '0) else $error("step committed with no steps left");

endmodule

>>> test/ball_trajectory_integrator_tb.sv
// Self-checking testbench for the ball trajectory integrator.
`timescale 1ns / 1ps
module ball_trajectory_integrator_tb;
    import btint_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam logic       OP_START   = 1'b0;
    localparam logic       OP_ADVANCE = 1'b1;
    localparam int         STALL_PCT  = 13;
    localparam int         HANG_LIMIT = 60000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_operation = 1'b0;
    logic signed [31:0] i_time_value = '0;
    logic signed [31:0] i_start_height = '0;
    logic signed [31:0] i_start_vx = '0;
    logic signed [31:0] i_start_vy = '0;
    logic signed [31:0] i_start_lift = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_time_reached;
    logic [STEP_W-1:0]  o_steps_taken;
    logic               o_steps_clipped;

    ball_trajectory_integrator u_top (.*);

    always #4 i_clk = ~i_clk;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] time_reached;
        logic [8:0]         steps;
        logic               clipped;
    } flight_point_t;

    // trajectory predictor plus store of expected result words
    class flight_board;
        longint drag_lam, drag_tur, crit_spd, lift_dec, start_x, step_len, grav;
        longint t_now, bx, by, bvx, bvy, lift;
        flight_point_t expected_q[$];
        int errors, results, clipped_seen, words;

        function new();
            drag_lam = 0; drag_tur = 0; crit_spd = 0; lift_dec = 0;
            start_x = START_X_RST; step_len = STEP_LEN_RST; grav = GRAVITY_RST;
            t_now = 0; bx = 0; by = 0; bvx = 0; bvy = 0; lift = 0;
            errors = 0; results = 0; clipped_seen = 0; words = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // product shifted right, rounding toward minus infinity
        function longint fmul(longint a, longint b, int s);
            return (a * b) >>> s;
        endfunction

        function longint unsigned root64(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            longint u31, s32;
            u31 = longint'({33'd0, data[30:0]});
            s32 = longint'(signed'(data));
            case (idx)
                CFG_DRAG_LAM: drag_lam = u31;
                CFG_DRAG_TUR: drag_tur = u31;
                CFG_CRIT_SPD: crit_spd = u31;
                CFG_LIFT_DEC: lift_dec = s32;
                CFG_START_X:  start_x  = s32;
                CFG_STEP_LEN: step_len = u31;
                CFG_GRAVITY:  grav     = s32;
                default: ;
            endcase
        endfunction

        function void euler_step(longint dt);
            longint unsigned sq;
            longint spd, drag, dv, ax, ay, dvx, dvy;
            sq = longint'(bvx * bvx) + longint'(bvy * bvy);
            spd = longint'(root64(sq));
            drag = (spd < crit_spd) ? drag_lam : drag_tur;
            dv = clamp32(fmul(drag, spd, 28));
            ax = clamp32(-fmul(dv, bvx, 16) + fmul(lift, bvy, 28));
            ay = clamp32(-fmul(dv, bvy, 16) - fmul(lift, bvx, 28) + grav);
            dvx = clamp32(fmul(ax, dt, 16));
            dvy = clamp32(fmul(ay, dt, 16));
            bx = clamp32(bx + fmul(bvx, dt, 16) + fmul(dvx, dt, 17));
            by = clamp32(by + fmul(bvy, dt, 16) + fmul(dvy, dt, 17));
            bvx = clamp32(bvx + dvx);
            bvy = clamp32(bvy + dvy);
            t_now = clamp32(t_now + dt);
            lift = clamp32(lift - fmul(lift_dec, dt, 16));
        endfunction

        // accepted input word: start loads state, advance predicts one result
        function void note_word(logic op, logic signed [31:0] tv, logic signed [31:0] h,
                                logic signed [31:0] vx, logic signed [31:0] vy,
                                logic signed [31:0] lf);
            longint delta, dxq, steps, dt;
            longint unsigned raw, den;
            flight_point_t p;
            words++;
            if (op == OP_START) begin
                t_now = tv; bx = start_x; by = h; bvx = vx; bvy = vy; lift = lf;
                return;
            end
            delta = longint'(tv) - t_now;
            dxq = delta * bvx;
            raw = 0;
            if (dxq > 0) begin
                den = longint'(step_len < 1 ? 1 : step_len) << 16;
                raw = (longint'(dxq) + (den >> 1)) / den;
            end
            p.clipped = 1'b0;
            if (raw < 1) steps = 1;
            else if (raw > MAX_STEPS) begin
                steps = MAX_STEPS;
                p.clipped = 1'b1;
            end else steps = longint'(raw);
            dt = clamp32(delta / steps);
            for (int i = 0; i < steps; i++) euler_step(dt);
            p.pos_x = bx[31:0];
            p.pos_y = by[31:0];
            p.time_reached = t_now[31:0];
            p.steps = steps[8:0];
            expected_q.push_back(p);
        endfunction

        function void check_word(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] tr, logic [8:0] st, logic cl);
            flight_point_t p;
            if (expected_q.size() == 0) begin
                $error("unexpected result word: pos_x %0d pos_y %0d", px, py);
                errors++;
                return;
            end
            p = expected_q.pop_front();
            results++;
            if (cl) clipped_seen++;
            if (px !== p.pos_x) begin
                $error("pos_x: expected %0d, got %0d", p.pos_x, px); errors++;
            end
            if (py !== p.pos_y) begin
                $error("pos_y: expected %0d, got %0d", p.pos_y, py); errors++;
            end
            if (tr !== p.time_reached) begin
                $error("time_reached: expected %0d, got %0d", p.time_reached, tr); errors++;
            end
            if (st !== p.steps) begin
                $error("steps_taken: expected %0d, got %0d", p.steps, st); errors++;
            end
            if (cl !== p.clipped) begin
                $error("steps_clipped: expected %0d, got %0d", p.clipped, cl); errors++;
            end
        endfunction
    endclass

    flight_board board = new();
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int sent = 0;

    // receiver: checks result words, random stalls, long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                board.check_word(o_pos_x, o_pos_y, o_time_reached, o_steps_taken,
                                 o_steps_clipped);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!idle_on) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < STALL_PCT);
            end
        end
    end

    // watchdog: cycles in which no word moves on either channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
            if (quiet >= HANG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(logic op, logic signed [31:0] tv, logic signed [31:0] h,
                             logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] lf);
        if (idle_on && $urandom_range(0, 99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_time_value   <= tv;
        i_start_height <= h;
        i_start_vx     <= vx;
        i_start_vy     <= vy;
        i_start_lift   <= lf;
        do @(posedge i_clk); while (o_in_stall);
        board.note_word(op, tv, h, vx, vy, lf);
        sent++;
    endtask

    task automatic wait_drained();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [31:0] lam, logic [31:0] tur, logic [31:0] crit,
                             logic [31:0] dec, logic [31:0] sx, logic [31:0] sl,
                             logic [31:0] g);
        write_reg(CFG_DRAG_LAM, lam);
        write_reg(CFG_DRAG_TUR, tur);
        write_reg(CFG_CRIT_SPD, crit);
        write_reg(CFG_LIFT_DEC, dec);
        write_reg(CFG_START_X, sx);
        write_reg(CFG_STEP_LEN, sl);
        write_reg(CFG_GRAVITY, g);
    endtask

    task automatic write_moderate();
        write_all($urandom_range(0, 32'h20_0000), $urandom_range(0, 32'h20_0000),
                  $urandom_range(0, 32'h50_0000), $urandom_range(0, 32'h200_0000) - 32'h100_0000,
                  $urandom_range(0, 32'h400_0000) - 32'h200_0000,
                  $urandom_range(32'h2000, 32'h4_0000),
                  $urandom_range(0, 32'h600_0000) - 32'h300_0000);
    endtask

    function automatic logic signed [31:0] spread(int unsigned span);
        return signed'($urandom_range(0, 2 * span)) - signed'(span);
    endfunction

    // mostly plausible flights (start then short advances), some raw noise
    task automatic random_words(int n, int hold_at = -1, int pause_at = -1);
        int base;
        logic signed [31:0] t;
        base = sent;
        while (sent - base < n) begin
            if (hold_at >= 0 && sent - base >= hold_at) begin
                hold_req = 1'b1;
                hold_at = -1;
            end
            if (pause_at >= 0 && sent - base >= pause_at) begin
                wait_drained();
                pause_at = -1;
            end
            if ($urandom_range(0, 99) < 2) begin
                send_word(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            end else begin
                t = $urandom_range(0, 32'h10_0000);
                send_word(OP_START, t, $urandom_range(0, 32'h10_0000),
                          spread(32'h64_0000), spread(32'h64_0000), spread(32'h100_0000));
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 99) < 5) t = t - $urandom_range(0, 32'h1000);
                    else t = t + $urandom_range(0, 32'h1000);
                    send_word(OP_ADVANCE, t, $urandom, $urandom, $urandom, $urandom);
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults, field extremes, past targets, no motion, clipping
        send_word(OP_ADVANCE, 32'sh0001_0000, '0, '0, '0, '0);
        send_word(OP_START, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF);
        send_word(OP_ADVANCE, 32'sh8000_0000, '1, '1, '1, '1);
        send_word(OP_START, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000);
        send_word(OP_ADVANCE, 32'sh7FFF_FFFF, '0, '0, '0, '0);
        send_word(OP_START, 32'sh8000_0000, 0, 32'sh8000_0000, 0, 0);
        send_word(OP_ADVANCE, 32'sh8000_0000 + 32'sh0000_0100, '0, '0, '0, '0);
        send_word(OP_START, 0, 32'sh0010_0000, 0, 32'sh0020_0000, 0);
        send_word(OP_ADVANCE, 32'sh0001_0000, '0, '0, '0, '0);
        send_word(OP_START, 32'sh0001_0000, 0, 32'sh0032_0000, 32'sh0010_0000,
                  32'sh0100_0000);
        send_word(OP_ADVANCE, 32'sh0000_8000, '0, '0, '0, '0);
        send_word(OP_ADVANCE, 32'sh0000_8000, '0, '0, '0, '0);
        send_word(OP_ADVANCE, 32'sh0000_9000, '0, '0, '0, '0);
        send_word(OP_ADVANCE, 32'sh0002_0000, '0, '0, '0, '0);
        send_word(OP_START, 0, 0, 32'sh0032_0000, 0, 0);
        send_word(OP_START, 0, 32'sh0004_0000, 32'sh0028_0000, 32'sh0008_0000, 0);
        send_word(OP_ADVANCE, 32'sh0000_0800, '0, '0, '0, '0);

        // defaults, first half with no idling on either side
        idle_on = 1'b0;
        random_words(150);
        idle_on = 1'b1;
        random_words(150);

        wait_drained();
        write_moderate();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        random_words(300, 100);

        // extremes, with step length zero so each advance saturates
        wait_drained();
        write_all(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                  32'h7FFF_FFFF);
        send_word(OP_START, 0, 0, 32'sh0030_0000, 32'sh0010_0000, 32'sh0100_0000);
        send_word(OP_ADVANCE, 32'sh0000_0800, '0, '0, '0, '0);
        send_word(OP_ADVANCE, 32'sh0000_1000, '0, '0, '0, '0);

        wait_drained();
        write_all(0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000);
        random_words(100);

        wait_drained();
        write_moderate();
        random_words(330, -1, 150);

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("run: %0d input words, %0d results checked, %0d with saturated step count",
                 board.words, board.results, board.clipped_seen);
        $display("covered default, moderate and extreme register settings with random stalls");
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", board.errors,
                     board.expected_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/btint_pkg.sv
hw/rtl/btint_sqrt.sv
hw/rtl/btint_div.sv
hw/rtl/btint_ctrl.sv
hw/rtl/btint_datapath.sv
hw/rtl/ball_trajectory_integrator.sv
test/ball_trajectory_integrator_tb.sv
